// ===== rtl/fir8r_pkg.sv =====
package fir8r_pkg;

	// Fixed field and register widths
	localparam int SMP_W        = 8;
	localparam int COEFF_W      = 8;
	localparam int ACC_W        = 16;
	localparam int CFG_W        = 64;
	localparam int TAPS_W       = 5;
	localparam int COEFF_NUM    = 16;
	localparam int COEFF_PER_WD = CFG_W / COEFF_W;
	localparam int MAX_TAPS_DEF = 16;
	localparam int TAPS_RESET   = 16;

	// Rounding: arithmetic shift right, add bias, then one more shift right
	localparam int ROUND_SHIFT  = 6;
	localparam int ROUND_BIAS   = 1;

	// Work queue between front and back
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = $clog2(Q_DEPTH);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TAP_COUNT  = 2'd0,
		REG_COEFF_LOW  = 2'd1,
		REG_COEFF_HIGH = 2'd2
	} reg_idx_t;

	// One unit of work for the back end: a sample to shift in, and the end-of-block mark
	typedef struct packed {
		logic signed [SMP_W-1:0] smp;
		logic                    last;
	} work_t;

	// Settings seen by front and back
	typedef struct packed {
		logic [TAPS_W-1:0]                 taps;
		logic [COEFF_NUM-1:0][COEFF_W-1:0] coeff;
	} cfg_t;

endpackage

// ===== rtl/fir8r_if.sv =====
// Sample channel
interface fir8r_in_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] sample;
	logic              last_in;

	modport source (output valid, output sample, output last_in, input ready);
	modport sink (input valid, input sample, input last_in, output ready);
endinterface

// Result channel
interface fir8r_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] filtered;
	logic              out_last;

	modport source (output valid, output filtered, output out_last, input ready);
	modport sink (input valid, input filtered, input out_last, output ready);
endinterface

// ===== rtl/fir8r_front.sv =====
module fir8r_front #(
	parameter int MAX_TAPS = fir8r_pkg::MAX_TAPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fir8r_in_if.sink                      samples,
	input  logic [fir8r_pkg::TAPS_W-1:0]  taps,
	input  logic                          q_full,
	output logic                          q_push,
	output fir8r_pkg::work_t              q_wdata
);
	import fir8r_pkg::*;

	localparam int REM_W = $clog2(MAX_TAPS);

	logic             tail_q;
	logic [REM_W-1:0] rem_q;
	logic             acc_beat;
	logic             single_tap;

	assign single_tap = (taps == TAPS_W'(1));
	assign acc_beat   = samples.valid && samples.ready;

	// Samples are held off while the tail of a block is being generated.
	always_comb begin
		samples.ready = !tail_q && !q_full;
		if (tail_q) begin
			q_push       = !q_full;
			q_wdata.smp  = '0;
			q_wdata.last = (rem_q == REM_W'(1));
		end else begin
			q_push       = acc_beat;
			q_wdata.smp  = samples.sample;
			q_wdata.last = samples.last_in && single_tap;
		end
	end

	// Tail counter: taps-1 zero samples follow the last sample of a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
			rem_q  <= '0;
		end else if (acc_beat && samples.last_in && !single_tap) begin
			tail_q <= 1'b1;
			rem_q  <= REM_W'(taps - TAPS_W'(1));
		end else if (tail_q && !q_full) begin
			rem_q <= rem_q - REM_W'(1);
			if (rem_q == REM_W'(1)) begin
				tail_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fir8r_queue.sv =====
module fir8r_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fir8r_pkg::work_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output fir8r_pkg::work_t rdata
);
	import fir8r_pkg::*;

	work_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full   = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign rvalid = (cnt_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/fir8r_back.sv =====
module fir8r_back #(
	parameter int MAX_TAPS = fir8r_pkg::MAX_TAPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fir8r_pkg::cfg_t  cfg,
	input  logic             q_valid,
	input  fir8r_pkg::work_t q_rdata,
	output logic             q_pop,
	fir8r_out_if.source      results
);
	import fir8r_pkg::*;

	localparam int NGRP  = (MAX_TAPS + 3) / 4;
	localparam int NLANE = NGRP * 4;

	logic signed [SMP_W-1:0] dl_q [MAX_TAPS-1];
	logic [ACC_W-1:0]        prod_s1 [NLANE];
	logic [ACC_W-1:0]        lane_prod [NLANE];
	logic [ACC_W-1:0]        psum_s2 [NGRP];
	logic [ACC_W-1:0]        grp_sum [NGRP];
	logic                    vld_s1, vld_s2, vld_s3;
	logic                    last_s1, last_s2, last_s3;
	logic [SMP_W-1:0]        filt_s3;
	logic [ACC_W-1:0]        acc;
	logic signed [ACC_W-1:0] sh;
	logic [ACC_W-1:0]        rnd;
	logic                    adv;

	// The whole pipeline moves when the result register is free or being taken.
	assign adv   = !vld_s3 || results.ready;
	assign q_pop = q_valid && adv;

	assign results.valid    = vld_s3;
	assign results.filtered = filt_s3;
	assign results.out_last = last_s3;

	// One multiplier per tap; taps beyond the active count give zero.
	always_comb begin
		logic signed [SMP_W-1:0]   x;
		logic signed [ACC_W:0]     p;
		for (int k = 0; k < NLANE; k++) begin
			lane_prod[k] = '0;
			if (k < MAX_TAPS) begin
				x = (k == 0) ? q_rdata.smp : dl_q[(k == 0) ? 0 : k - 1];
				p = $signed({1'b0, cfg.coeff[k]}) * x;
				if (TAPS_W'(k) < cfg.taps) begin
					lane_prod[k] = p[ACC_W-1:0];
				end
			end
		end
	end

	// Partial sums over groups of four products
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_sum[g] = prod_s1[4*g] + prod_s1[4*g+1] + prod_s1[4*g+2] + prod_s1[4*g+3];
		end
	end

	// Final sum, wrapping at 16 bits, then rounding to 8 bits
	always_comb begin
		acc = '0;
		for (int g = 0; g < NGRP; g++) begin
			acc = acc + psum_s2[g];
		end
		sh  = $signed(acc) >>> ROUND_SHIFT;
		rnd = sh + ACC_W'(ROUND_BIAS);
	end

	// Delay line shifts on every popped beat and clears after the block's final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS - 1; i++) begin
				dl_q[i] <= '0;
			end
		end else if (q_pop) begin
			for (int i = 0; i < MAX_TAPS - 1; i++) begin
				if (q_rdata.last) begin
					dl_q[i] <= '0;
				end else if (i == 0) begin
					dl_q[i] <= q_rdata.smp;
				end else begin
					dl_q[i] <= dl_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NLANE; k++) begin
				prod_s1[k] <= lane_prod[k];
			end
			last_s1 <= q_rdata.last;
			for (int g = 0; g < NGRP; g++) begin
				psum_s2[g] <= grp_sum[g];
			end
			last_s2 <= last_s1;
			filt_s3 <= rnd[SMP_W:1];
			last_s3 <= last_s2;
		end
	end

endmodule

// ===== rtl/fir_filter_int8_rounded.sv =====
// Channel  | Direction | Beat fields         | Notes
// samples  | sink      | sample, last_in     | last_in closes a block
// results  | source    | filtered, out_last  | out_last on the block's final output
// cfg_*    | write     | cfg_idx, cfg_wdata  | tap_count, coeff_word_low, coeff_word_high
//
// One sample is taken per cycle while the work queue is not full; a sample
// with last_in set is followed by (clamped tap count)-1 tail outputs, during
// which samples are held off. A pushed beat passes the work queue, then the
// multiply, group sum and rounded final sum registers before its result is valid.
// A stall on results freezes the back pipeline; the four-entry queue lets the
// front keep taking samples until it fills. Reset clears the delay line and queue.
module fir_filter_int8_rounded #(
	parameter int MAX_TAPS = fir8r_pkg::MAX_TAPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fir8r_in_if.sink                    samples,
	fir8r_out_if.source                 results,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [fir8r_pkg::CFG_W-1:0] cfg_wdata
);
	import fir8r_pkg::*;

	logic [TAPS_W-1:0] tap_count_q;
	logic [CFG_W-1:0]  coeff_lo_q;
	logic [CFG_W-1:0]  coeff_hi_q;
	cfg_t              cfg;
	logic              q_push, q_full, q_pop, q_valid;
	work_t             q_wdata, q_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAPS_W'(TAPS_RESET);
			coeff_lo_q  <= '0;
			coeff_hi_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_TAP_COUNT:  tap_count_q <= cfg_wdata[TAPS_W-1:0];
				REG_COEFF_LOW:  coeff_lo_q  <= cfg_wdata;
				REG_COEFF_HIGH: coeff_hi_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Active tap count clamped to 1..MAX_TAPS, coefficients unpacked
	always_comb begin
		if (tap_count_q == '0) begin
			cfg.taps = TAPS_W'(1);
		end else if (tap_count_q > TAPS_W'(MAX_TAPS)) begin
			cfg.taps = TAPS_W'(MAX_TAPS);
		end else begin
			cfg.taps = tap_count_q;
		end
		for (int k = 0; k < COEFF_PER_WD; k++) begin
			cfg.coeff[k]                = coeff_lo_q[k*COEFF_W +: COEFF_W];
			cfg.coeff[k + COEFF_PER_WD] = coeff_hi_q[k*COEFF_W +: COEFF_W];
		end
	end

	fir8r_front #(.MAX_TAPS(MAX_TAPS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.taps    (cfg.taps),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	fir8r_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	fir8r_back #(.MAX_TAPS(MAX_TAPS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.results (results)
	);

	// The back end never pops an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("work queue popped while empty");

	// The front end never pushes into a full queue.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("work queue pushed while full");

	// A block's last sample with more than one tap starts a tail that holds off samples.
	a_tail_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.last_in && cfg.taps != TAPS_W'(1))
		|=> !samples.ready)
		else $error("samples accepted during tail generation");

endmodule

// ===== sim/fir8r_output_monitor.sv =====
`timescale 1ns / 1ps
module fir8r_output_monitor
	import fir8r_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	fir8r_in_if              smp,
	fir8r_out_if             res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               pending,
	output int               mismatches
);

	typedef struct packed {
		logic [SMP_W-1:0] filtered;
		logic             out_last;
	} out_beat_t;

	// Mirror of the filter settings and of the sample history.
	logic [TAPS_W-1:0] taps_reg;
	logic [CFG_W-1:0]  coeff_lo;
	logic [CFG_W-1:0]  coeff_hi;
	logic [SMP_W-1:0]  history [MAX_TAPS_DEF-1];
	out_beat_t         due_outputs [$];
	int                err_cnt = 0;

	// A zero count acts as one tap and counts above the maximum saturate.
	function automatic int live_taps();
		if (taps_reg == '0)
			return 1;
		if (taps_reg > MAX_TAPS_DEF)
			return MAX_TAPS_DEF;
		return int'(taps_reg);
	endfunction

	function automatic logic [COEFF_W-1:0] coeff_of(int k);
		logic [CFG_W-1:0] word;
		word = (k < COEFF_PER_WD) ? coeff_lo : coeff_hi;
		return word[(k % COEFF_PER_WD) * COEFF_W +: COEFF_W];
	endfunction

	// One filter output with cur as the newest sample; cur then enters the history.
	function automatic logic [SMP_W-1:0] filter_sample(logic [SMP_W-1:0] cur);
		logic [ACC_W-1:0]        acc;
		logic [ACC_W-1:0]        c_wide;
		logic [ACC_W-1:0]        x_wide;
		logic [SMP_W-1:0]        x;
		logic signed [ACC_W-1:0] rounded;
		int                      n;
		acc = '0;
		n = live_taps();
		for (int k = 0; k < n; k++) begin
			x = (k == 0) ? cur : history[k - 1];
			c_wide = {{(ACC_W - COEFF_W){1'b0}}, coeff_of(k)};
			x_wide = {{(ACC_W - SMP_W){x[SMP_W - 1]}}, x};
			acc = acc + c_wide * x_wide;
		end
		// Arithmetic shift, add the bias, then one more arithmetic shift.
		rounded = ($signed(acc) >>> ROUND_SHIFT) + ROUND_BIAS;
		rounded = rounded >>> 1;
		for (int k = MAX_TAPS_DEF - 2; k > 0; k--)
			history[k] = history[k - 1];
		history[0] = cur;
		return rounded[SMP_W - 1:0];
	endfunction

	// Compare result beats, predict from sample beats, then track register writes.
	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		out_beat_t got;
		int        n;
		if (!arst_n) begin
			taps_reg = TAPS_RESET;
			coeff_lo = '0;
			coeff_hi = '0;
			foreach (history[k])
				history[k] = '0;
			due_outputs.delete();
			pending <= 0;
			mismatches <= err_cnt;
		end else begin
			if (res.valid && res.ready) begin
				got.filtered = res.filtered;
				got.out_last = res.out_last;
				if (due_outputs.size() == 0) begin
					if (err_cnt < 10)
						$display("[%0t] result beat with nothing outstanding: filtered=%0d out_last=%0b",
							$time, $signed(got.filtered), got.out_last);
					err_cnt++;
				end else begin
					want = due_outputs.pop_front();
					if (want.filtered !== got.filtered || want.out_last !== got.out_last) begin
						if (err_cnt < 10)
							$display("[%0t] result mismatch: expected filtered=%0d out_last=%0b, got filtered=%0d out_last=%0b",
								$time, $signed(want.filtered), want.out_last,
								$signed(got.filtered), got.out_last);
						err_cnt++;
					end
				end
			end

			if (smp.valid && smp.ready) begin
				n = live_taps();
				want.filtered = filter_sample(smp.sample);
				want.out_last = 1'b0;
				due_outputs.push_back(want);
				// A closing sample flushes the tail with zeros and clears the history.
				if (smp.last_in) begin
					for (int t = 1; t < n; t++) begin
						want.filtered = filter_sample('0);
						due_outputs.push_back(want);
					end
					want = due_outputs.pop_back();
					want.out_last = 1'b1;
					due_outputs.push_back(want);
					foreach (history[k])
						history[k] = '0;
				end
			end

			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_TAP_COUNT: begin
						taps_reg = cfg_wdata[TAPS_W - 1:0];
					end
					REG_COEFF_LOW: begin
						coeff_lo = cfg_wdata;
					end
					REG_COEFF_HIGH: begin
						coeff_hi = cfg_wdata;
					end
					default: begin
					end
				endcase
			end

			pending <= due_outputs.size();
			mismatches <= err_cnt;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import fir8r_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_WAIT    = 8;
	localparam int ITEM_TARGET  = 350;

	typedef enum int {RX_STEADY, RX_CHOPPY, RX_LONG_STALL} rx_style_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;
	int               pending;
	int               mismatches;
	int               cycles = 0;
	int               burst_left = 0;
	int               items_sent = 0;
	int               stall_left = 0;
	int               style_left = 0;
	rx_style_t        rx_style = RX_STEADY;

	fir8r_in_if  smp_bus ();
	fir8r_out_if res_bus ();

	fir_filter_int8_rounded uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp_bus),
		.results   (res_bus),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	fir8r_output_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_bus),
		.res        (res_bus),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.pending    (pending),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result backpressure: the style changes every so often, from none to long stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 2));
				style_left = $urandom_range(20, 150);
			end else begin
				style_left--;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_STEADY: begin
						res_bus.ready <= 1'b1;
					end
					RX_CHOPPY: begin
						res_bus.ready <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						if ($urandom_range(0, 9) == 0) begin
							stall_left = $urandom_range(4, 11);
							res_bus.ready <= 1'b0;
						end else begin
							res_bus.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Present one sample beat and wait for it to be taken; bursts are broken by short gaps.
	task automatic send_sample(input logic [SMP_W-1:0] s, input logic closes);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				smp_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		smp_bus.valid   <= 1'b1;
		smp_bus.sample  <= s;
		smp_bus.last_in <= closes;
		@(posedge clk);
		while (!smp_bus.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Hold off the sender until every predicted output has been received.
	task automatic wait_idle();
		smp_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic program_filter(input logic [CFG_W-1:0] taps_word,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_TAP_COUNT;
		cfg_wdata <= taps_word;
		@(posedge clk);
		cfg_idx   <= REG_COEFF_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_idx   <= REG_COEFF_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'hFF;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// Random upper bits ride along with the tap count field.
	function automatic logic [CFG_W-1:0] pick_taps_word();
		logic [CFG_W-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: w[TAPS_W - 1:0] = '0;
			1: w[TAPS_W - 1:0] = TAPS_W'(1);
			2: w[TAPS_W - 1:0] = TAPS_W'(MAX_TAPS_DEF);
			3: w[TAPS_W - 1:0] = TAPS_W'($urandom_range(MAX_TAPS_DEF + 1, 31));
			default: w[TAPS_W - 1:0] = TAPS_W'($urandom_range(1, MAX_TAPS_DEF));
		endcase
		return w;
	endfunction

	function automatic logic [CFG_W-1:0] pick_coeffs();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2: return {$urandom, $urandom} & 64'h0303_0303_0303_0303;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int blocks;
		int len;
		logic open_end;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_idx         <= REG_TAP_COUNT;
		cfg_wdata       <= '0;
		smp_bus.valid   <= 1'b0;
		smp_bus.sample  <= '0;
		smp_bus.last_in <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings after reset: sixteen taps, every coefficient zero.
		send_sample(8'h7F, 1'b0);
		send_sample(8'h80, 1'b1);
		wait_idle();

		// Single tap: the closing sample's own output carries the end mark.
		program_filter(64'd1, 64'hFF, '0);
		send_sample(8'h7F, 1'b0);
		send_sample(8'h80, 1'b1);
		wait_idle();

		// A tap count of zero behaves as a single tap.
		program_filter(64'd0, 64'h80, '0);
		send_sample(8'h55, 1'b0);
		send_sample(8'hAA, 1'b1);
		wait_idle();

		// Count beyond the maximum saturates; full-scale coefficients wrap the accumulator.
		program_filter('1, '1, '1);
		send_sample(8'h7F, 1'b0);
		send_sample(8'h7F, 1'b0);
		send_sample(8'h7F, 1'b0);
		send_sample(8'h80, 1'b0);
		send_sample(8'h80, 1'b1);
		wait_idle();

		// All sixteen taps with a walking-bit coefficient pattern.
		program_filter(64'd16, 64'h0102_0408_1020_4080, 64'h8040_2010_0804_0201);
		send_sample(8'h01, 1'b0);
		send_sample(8'hFF, 1'b0);
		send_sample(8'h7F, 1'b1);
		wait_idle();

		// Tap count changed in the middle of a block keeps the history.
		program_filter(64'd4, 64'h4040_4040_4040_4040, 64'h1111_1111_1111_1111);
		send_sample(8'h20, 1'b0);
		send_sample(8'hE0, 1'b0);
		send_sample(8'h7F, 1'b0);
		wait_idle();
		program_filter(64'd9, 64'h4040_4040_4040_4040, 64'h1111_1111_1111_1111);
		send_sample(8'h80, 1'b0);
		send_sample(8'h10, 1'b0);
		send_sample(8'h01, 1'b1);

		// Random phases: new settings each time, a few blocks, sometimes left open.
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			program_filter(pick_taps_word(), pick_coeffs(), pick_coeffs());
			blocks = $urandom_range(1, 6);
			for (int b = 0; b < blocks; b++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				open_end = (b == blocks - 1) && ($urandom_range(0, 3) == 0);
				for (int i = 0; i < len; i++)
					send_sample(pick_sample(), (i == len - 1) && !open_end);
			end
		end

		wait_idle();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
